/* hdl/i2cbc_pkg.sv */
package i2cbc_pkg;

    typedef enum logic [1:0] {
        REG_SETTLE_TICKS      = 2'd0,
        REG_HALF_PERIOD_TICKS = 2'd1,
        REG_MAX_PULSES        = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        OUT_CLEARED = 2'd0,
        OUT_SCL_BAD = 2'd1,
        OUT_SDA_BAD = 2'd2
    } t_outcome;

    localparam logic [15:0] SETTLE_TICKS_RST      = 16'd10000;
    localparam logic [9:0]  HALF_PERIOD_TICKS_RST = 10'd10;
    localparam logic [5:0]  MAX_PULSES_RST        = 6'd20;

    typedef struct packed {
        logic [15:0] settle_ticks;
        logic [9:0]  half_period_ticks;
        logic [5:0]  max_pulses;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  reg_index;
        logic [15:0] wdata;
    } t_cfg_wr;

    typedef struct packed {
        logic start_request;
        logic scl_level;
        logic sda_level;
    } t_in_item;

    typedef struct packed {
        logic     scl_pull_low;
        logic     sda_pull_low;
        logic     busy_res;
        logic     finished;
        t_outcome outcome;
    } t_res_item;

endpackage

/* hdl/i2cbc_stream_if.sv */
interface i2cbc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/i2cbc_cfg_regs.sv */
module i2cbc_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  i2cbc_pkg::t_cfg_wr i_wr,
    output i2cbc_pkg::t_cfg    o_cfg
);
    import i2cbc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ticks      <= SETTLE_TICKS_RST;
            r_cfg.half_period_ticks <= HALF_PERIOD_TICKS_RST;
            r_cfg.max_pulses        <= MAX_PULSES_RST;
        end else if (i_wr_en) begin
            case (i_wr.reg_index)
                REG_SETTLE_TICKS:      r_cfg.settle_ticks      <= i_wr.wdata;
                REG_HALF_PERIOD_TICKS: r_cfg.half_period_ticks <= i_wr.wdata[9:0];
                REG_MAX_PULSES:        r_cfg.max_pulses        <= i_wr.wdata[5:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/i2cbc_seq.sv */
module i2cbc_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  i2cbc_pkg::t_in_item  i_item,
    input  i2cbc_pkg::t_cfg      i_cfg,
    output i2cbc_pkg::t_res_item o_res
);
    import i2cbc_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_SETTLE   = 3'd1,
        PH_SCL_LOW  = 3'd2,
        PH_SCL_HIGH = 3'd3,
        PH_SDA_LOW  = 3'd4,
        PH_SDA_HIGH = 3'd5
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_timer, n_timer;
    logic [5:0]  r_pulses, n_pulses;
    logic        sample;
    logic        done;
    t_outcome    code;
    logic [15:0] half_ticks;

    assign half_ticks = {6'd0, i_cfg.half_period_ticks};

    always_comb begin
        n_phase  = r_phase;
        n_timer  = r_timer;
        n_pulses = r_pulses;
        sample   = 1'b0;
        done     = 1'b0;
        code     = OUT_CLEARED;
        if (r_phase != PH_IDLE && r_timer > 16'd1) begin
            n_timer = r_timer - 16'd1;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_item.start_request) begin
                        n_phase  = PH_SETTLE;
                        n_timer  = i_cfg.settle_ticks;
                        n_pulses = i_cfg.max_pulses;
                    end
                end
                PH_SETTLE: begin
                    if (!i_item.scl_level) begin
                        n_phase = PH_IDLE;
                        n_timer = 16'd0;
                        done    = 1'b1;
                        code    = OUT_SCL_BAD;
                    end else begin
                        sample = 1'b1;
                    end
                end
                PH_SCL_LOW: begin
                    n_phase = PH_SCL_HIGH;
                    n_timer = half_ticks;
                end
                PH_SCL_HIGH: begin
                    sample = 1'b1;
                end
                PH_SDA_LOW: begin
                    n_phase = PH_SDA_HIGH;
                    n_timer = half_ticks;
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_timer = 16'd0;
                    done    = 1'b1;
                    code    = OUT_CLEARED;
                end
            endcase
        end

        // SDA check after settle or after a released SCL half
        if (sample) begin
            if (i_item.sda_level) begin
                n_phase = PH_SDA_LOW;
                n_timer = half_ticks;
            end else if (r_pulses != 6'd0) begin
                n_pulses = r_pulses - 6'd1;
                n_phase  = PH_SCL_LOW;
                n_timer  = half_ticks;
            end else begin
                n_phase = PH_IDLE;
                n_timer = 16'd0;
                done    = 1'b1;
                code    = OUT_SDA_BAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_timer  <= 16'd0;
            r_pulses <= 6'd0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_timer  <= n_timer;
            r_pulses <= n_pulses;
        end
    end

    assign o_res.scl_pull_low = (n_phase == PH_SCL_LOW);
    assign o_res.sda_pull_low = (n_phase == PH_SDA_LOW);
    assign o_res.busy_res     = (n_phase != PH_IDLE);
    assign o_res.finished     = done;
    assign o_res.outcome      = done ? code : OUT_CLEARED;

endmodule

/* hdl/i2c_bus_clear_sequencer.sv */
// channel  dir  payload                                          accepted when
// i_item   in   start_request, scl_level, sda_level              valid & ready
// o_res    out  scl_pull_low, sda_pull_low, busy_res, finished,  valid & ready
//               outcome
// i_cfg    in   reg_index, wdata                                 valid & ready
//
// One item per cycle sustained while o_res is ready; each result passes the
// input register, then the result register after the phase/timer update.
// Synchronous active-low reset; config registers reset to 10000, 10, 20.
// A stalled o_res holds the result register and then the input register;
// i_item.ready drops only when both are full. i_cfg.ready is always high.
module i2c_bus_clear_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    i2cbc_stream_if.sink   i_item,
    i2cbc_stream_if.source o_res,
    i2cbc_stream_if.sink   i_cfg
);
    import i2cbc_pkg::*;

    t_cfg      cfg;
    t_in_item  r_in;
    logic      r_in_valid;
    t_res_item r_out;
    logic      r_out_valid;
    t_res_item res;
    logic      adv;
    logic      in_acc;

    assign adv    = r_in_valid && (!r_out_valid || o_res.ready);
    assign in_acc = i_item.valid && i_item.ready;

    assign i_item.ready = !r_in_valid || adv;
    assign i_cfg.ready  = 1'b1;

    i2cbc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg.valid),
        .i_wr    (i_cfg.data),
        .o_cfg   (cfg)
    );

    i2cbc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_item.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

`ifndef SYNTHESIS
    a_finish_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.finished |-> !r_out.busy_res && !r_out.scl_pull_low
            && !r_out.sda_pull_low)
        else $error("finishing result still busy or driving a line");

    a_outcome_needs_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.finished |-> r_out.outcome == OUT_CLEARED)
        else $error("outcome set without finished");

    a_one_line_driven: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.scl_pull_low && r_out.sda_pull_low))
        else $error("both lines driven low");

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("result register not loaded after a step");
`endif

endmodule

/* tb/sv/i2c_bus_clear_sequencer_checker.sv */
module i2c_bus_clear_sequencer_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    input  logic                 i_item_ready,
    input  i2cbc_pkg::t_in_item  i_item_data,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  i2cbc_pkg::t_res_item i_res_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  i2cbc_pkg::t_cfg_wr   i_cfg_data,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_results,
    output int                   o_cleared,
    output int                   o_scl_stuck,
    output int                   o_sda_stuck
);
    import i2cbc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETTLE,
        ST_SCL_LOW,
        ST_SCL_HIGH,
        ST_SDA_LOW,
        ST_SDA_HIGH
    } t_step;

    t_cfg        regs;
    t_step       step;
    logic [15:0] tick_cnt;
    logic [5:0]  pulses_left;
    logic        seq_done;
    t_outcome    seq_code;
    t_res_item   bus_status_q [$];
    t_res_item   next_status;

    task automatic report(input string msg);
        o_errors++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [1:0] got,
                                 input logic [1:0] want);
        if (got !== want) begin
            report($sformatf("result %0d %s got %0d expected %0d",
                             o_results, name, got, want));
        end
    endtask

    task automatic end_sequence(input t_outcome code);
        step     = ST_IDLE;
        tick_cnt = '0;
        seq_done = 1'b1;
        seq_code = code;
    endtask

    // SDA sampled: pulse again, give up, or go on to start/stop
    task automatic sda_decision(input logic sda);
        if (!sda) begin
            if (pulses_left != '0) begin
                pulses_left = pulses_left - 6'd1;
                step        = ST_SCL_LOW;
                tick_cnt    = {6'd0, regs.half_period_ticks};
            end else begin
                end_sequence(OUT_SDA_BAD);
            end
        end else begin
            step     = ST_SDA_LOW;
            tick_cnt = {6'd0, regs.half_period_ticks};
        end
    endtask

    task automatic advance_recovery(input t_in_item it, output t_res_item r);
        logic expired;
        expired  = (tick_cnt <= 16'd1);
        seq_done = 1'b0;
        seq_code = OUT_CLEARED;
        if (step != ST_IDLE && !expired) begin
            tick_cnt = tick_cnt - 16'd1;
        end else begin
            case (step)
                ST_IDLE: begin
                    if (it.start_request) begin
                        step        = ST_SETTLE;
                        tick_cnt    = regs.settle_ticks;
                        pulses_left = regs.max_pulses;
                    end
                end
                ST_SETTLE: begin
                    if (!it.scl_level) begin
                        end_sequence(OUT_SCL_BAD);
                    end else begin
                        sda_decision(it.sda_level);
                    end
                end
                ST_SCL_LOW: begin
                    step     = ST_SCL_HIGH;
                    tick_cnt = {6'd0, regs.half_period_ticks};
                end
                ST_SCL_HIGH: sda_decision(it.sda_level);
                ST_SDA_LOW: begin
                    step     = ST_SDA_HIGH;
                    tick_cnt = {6'd0, regs.half_period_ticks};
                end
                default: end_sequence(OUT_CLEARED);
            endcase
        end
        r.scl_pull_low = (step == ST_SCL_LOW);
        r.sda_pull_low = (step == ST_SDA_LOW);
        r.busy_res     = (step != ST_IDLE);
        r.finished     = seq_done;
        r.outcome      = seq_done ? seq_code : OUT_CLEARED;
    endtask

    task automatic apply_write(input t_cfg_wr w);
        case (w.reg_index)
            REG_SETTLE_TICKS:      regs.settle_ticks      = w.wdata;
            REG_HALF_PERIOD_TICKS: regs.half_period_ticks = w.wdata[9:0];
            REG_MAX_PULSES:        regs.max_pulses        = w.wdata[5:0];
            default: ;
        endcase
    endtask

    task automatic check_result(input t_res_item got);
        t_res_item want;
        if (bus_status_q.size() == 0) begin
            report($sformatf("result %0d arrived with nothing expected", o_results));
        end else begin
            want = bus_status_q.pop_front();
            compare_field("scl_pull_low", {1'b0, got.scl_pull_low},
                          {1'b0, want.scl_pull_low});
            compare_field("sda_pull_low", {1'b0, got.sda_pull_low},
                          {1'b0, want.sda_pull_low});
            compare_field("busy_res", {1'b0, got.busy_res}, {1'b0, want.busy_res});
            compare_field("finished", {1'b0, got.finished}, {1'b0, want.finished});
            compare_field("outcome", got.outcome, want.outcome);
            if (want.finished) begin
                case (want.outcome)
                    OUT_CLEARED: o_cleared++;
                    OUT_SCL_BAD: o_scl_stuck++;
                    default:     o_sda_stuck++;
                endcase
            end
        end
        o_results++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs        = '{SETTLE_TICKS_RST, HALF_PERIOD_TICKS_RST, MAX_PULSES_RST};
            step        = ST_IDLE;
            tick_cnt    = '0;
            pulses_left = '0;
            bus_status_q.delete();
            o_errors    = 0;
            o_results   = 0;
            o_cleared   = 0;
            o_scl_stuck = 0;
            o_sda_stuck = 0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                check_result(i_res_data);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                apply_write(i_cfg_data);
            end
            if (i_item_valid && i_item_ready) begin
                advance_recovery(i_item_data, next_status);
                bus_status_q.push_back(next_status);
            end
        end
        o_pending = bus_status_q.size();
    end

endmodule

/* tb/sv/i2c_bus_clear_sequencer_tb.sv */
module i2c_bus_clear_sequencer_tb;
    import i2cbc_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    // {start_request, scl_level, sda_level}
    localparam logic [2:0] TICKS_BASIC [22] = '{
        3'b100, 3'b000, 3'b000,                                 // SCL stuck
        3'b111, 3'b111, 3'b111, 3'b111, 3'b111,                 // clear, starts ignored
        3'b110, 3'b010, 3'b010, 3'b010, 3'b010, 3'b010, 3'b010, // SDA stuck
        3'b110, 3'b010, 3'b010, 3'b010, 3'b011, 3'b011, 3'b011  // freed by a pulse
    };
    localparam logic [2:0] TICKS_ZERO [6] = '{
        3'b111, 3'b011, 3'b011, 3'b011, 3'b110, 3'b010
    };

    logic i_clk;
    logic i_rst_n = 1'b0;
    bit   tx_idle;
    bit   rx_idle;
    bit   hold_req;
    int   n_settings;
    int   errors;
    int   pending;
    int   results;
    int   cleared;
    int   scl_stuck;
    int   sda_stuck;

    i2cbc_stream_if #(.T(t_in_item))  item_if ();
    i2cbc_stream_if #(.T(t_res_item)) res_if ();
    i2cbc_stream_if #(.T(t_cfg_wr))   cfg_if ();

    i2c_bus_clear_sequencer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    i2c_bus_clear_sequencer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_if.valid),
        .i_item_ready (item_if.ready),
        .i_item_data  (item_if.data),
        .i_res_valid  (res_if.valid),
        .i_res_ready  (res_if.ready),
        .i_res_data   (res_if.data),
        .i_cfg_valid  (cfg_if.valid),
        .i_cfg_ready  (cfg_if.ready),
        .i_cfg_data   (cfg_if.data),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_results    (results),
        .o_cleared    (cleared),
        .o_scl_stuck  (scl_stuck),
        .o_sda_stuck  (sda_stuck)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("timeout with %0d results outstanding", pending);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_tick(input t_in_item it);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.data  <= it;
        do @(posedge i_clk); while (!item_if.ready);
    endtask

    task automatic configure(input logic [15:0] settle, input logic [15:0] half,
                             input logic [15:0] pulses, input bit probe_unused);
        t_cfg_wr wr [$];
        if (probe_unused) begin
            wr.push_back('{reg_index: REG_UNUSED, wdata: 16'hFFFF});
        end
        wr.push_back('{reg_index: REG_SETTLE_TICKS, wdata: settle});
        wr.push_back('{reg_index: REG_HALF_PERIOD_TICKS, wdata: half});
        wr.push_back('{reg_index: REG_MAX_PULSES, wdata: pulses});
        foreach (wr[i]) begin
            cfg_if.valid <= 1'b1;
            cfg_if.data  <= wr[i];
            do @(posedge i_clk); while (!cfg_if.ready);
        end
        cfg_if.valid <= 1'b0;
        n_settings++;
    endtask

    // wait until every expected result has left the two-stage pipeline
    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int stall;
        res_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = 120;
            end else begin
                stall = rx_idle ? $urandom_range(0, 7) : 0;
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
        end
    end

    initial begin : stimulus
        t_in_item    it;
        int          scl_low_pct;
        int          sda_low_pct;
        logic [15:0] settle;
        logic [15:0] half;
        logic [15:0] pulses;
        item_if.valid <= 1'b0;
        item_if.data  <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.data   <= '0;
        tx_idle  = 1'b0;
        rx_idle  = 1'b0;
        hold_req = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero counts act as one; zero pulses give up at once; upper bits masked
        configure(16'd0, 16'hFC00, 16'hFFC0, 1'b1);
        foreach (TICKS_ZERO[i]) send_tick(t_in_item'(TICKS_ZERO[i]));
        item_if.valid <= 1'b0;
        drain();

        configure(16'd2, 16'd1, 16'd2, 1'b0);
        foreach (TICKS_BASIC[i]) send_tick(t_in_item'(TICKS_BASIC[i]));
        item_if.valid <= 1'b0;
        drain();

        // most pulses allowed, SDA never frees
        configure(16'd1, 16'hFC01, 16'hFFFF, 1'b0);
        send_tick(t_in_item'(3'b110));
        repeat (130) send_tick(t_in_item'(3'b010));
        item_if.valid <= 1'b0;
        drain();

        for (int setting = 0; setting < 7; setting++) begin
            settle = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 2))
                                                 : 16'($urandom_range(1, 16));
            half   = 16'($urandom_range(1, 4)) | (16'($urandom) & 16'hFC00);
            pulses = 16'($urandom_range(0, 6)) | (16'($urandom) & 16'hFFC0);
            configure(settle, half, pulses, setting == 2);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 2))
                0:       scl_low_pct = 0;
                1:       scl_low_pct = 5;
                default: scl_low_pct = 30;
            endcase
            case ($urandom_range(0, 3))
                0:       sda_low_pct = 0;
                1:       sda_low_pct = 40;
                2:       sda_low_pct = 85;
                default: sda_low_pct = 100;
            endcase
            if (setting == 3) begin
                hold_req = 1'b1;
            end
            repeat (230) begin
                if ($urandom_range(0, 9) == 0) begin
                    it = t_in_item'($urandom);
                end else begin
                    it.start_request = ($urandom_range(0, 3) == 0);
                    it.scl_level     = ($urandom_range(0, 99) >= scl_low_pct);
                    it.sda_level     = ($urandom_range(0, 99) >= sda_low_pct);
                end
                send_tick(it);
            end
            item_if.valid <= 1'b0;
            drain();
        end

        $display("%0d ticks checked across %0d register settings", results, n_settings);
        $display("sequences ended: %0d cleared, %0d SCL stuck, %0d SDA stuck",
                 cleared, scl_stuck, sda_stuck);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/i2cbc_pkg.sv
hdl/i2cbc_stream_if.sv
hdl/i2cbc_cfg_regs.sv
hdl/i2cbc_seq.sv
hdl/i2c_bus_clear_sequencer.sv
tb/sv/i2c_bus_clear_sequencer_checker.sv
tb/sv/i2c_bus_clear_sequencer_tb.sv
